[src/pvr_pkg.sv]
package pvr_pkg;

  // Field widths
  localparam int AdcBits   = 10;
  localparam int PwmBits   = 8;
  localparam int MvBits    = 13;
  localparam int GainBits  = 8;
  localparam int ActBits   = 2;
  localparam int CfgIdxBits = 2;

  // Stream word widths (fields packed from bit 0, padded to bytes)
  localparam int InDataBits  = 24;
  localparam int OutDataBits = 24;

  // Shared multiplier operand and product widths
  localparam int MulBits  = 26;
  localparam int ProdBits = 2 * MulBits;

  // Action codes
  localparam logic [ActBits-1:0] ActSample = 2'd0;
  localparam logic [ActBits-1:0] ActTarget = 2'd1;
  localparam logic [ActBits-1:0] ActPause  = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] RegGainProp  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegGainInteg = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegGainDeriv = 2'd2;

  // Configuration reset values
  localparam logic [GainBits-1:0] GainPropRst  = 8'd10;
  localparam logic [GainBits-1:0] GainIntegRst = 8'd4;
  localparam logic [GainBits-1:0] GainDerivRst = 8'd4;

  // Scaling constants
  localparam int RefMv  = 5000;
  localparam int PwmMax = (1 << PwmBits) - 1;
  localparam int Lim16  = 32767;

  // Reciprocals for the constant divides: floor(2^28/10) and floor(2^32/5000)
  localparam int DivTenShift = 28;
  localparam int DivTenRecip = (1 << DivTenShift) / 10;
  localparam int DutyShift   = 32;
  localparam longint DutyRecip = (64'd1 << DutyShift) / RefMv;

  typedef logic signed [MulBits-1:0]  mul_op_t;
  typedef logic signed [ProdBits-1:0] mul_prod_t;

endpackage

[src/pid_voltage_regulator_pwm.sv]
// Channel   Dir  Handshake          Word contents (lowest bit up)
// s_*       in   s_tvalid/s_tready  tdata: adc_sample[9:0], target_mv[22:10]; tuser: action[1:0]
// m_*       out  m_tvalid/m_tready  tdata: pwm_duty[7:0], drive_mv[20:8]; tuser: output_enabled
// cfg_*     in   cfg_we             cfg_index selects gain_prop/gain_integ/gain_deriv
//
// A sample word that runs the controller steps the sequencer from StMeas through
// StDfix to StDone; the sequencer issues at most one product per step to a
// single 26x26 multiplier. Target, pause and ignored words go straight to StDone.
// A new word is taken only in StIdle, after the last result word is loaded.
// Reset (rst, synchronous) restores default gains, clears integrator and history.
// A stalled result holds the sequencer in its last step until m_tready.
module pid_voltage_regulator_pwm
  import pvr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [InDataBits-1:0]    s_tdata,   // adc_sample[9:0], target_mv[22:10]
  input  logic [ActBits-1:0]       s_tuser,   // action[1:0]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OutDataBits-1:0]   m_tdata,   // pwm_duty[7:0], drive_mv[20:8]
  output logic                     m_tuser,   // output_enabled
  input  logic                     cfg_we,
  input  logic [CfgIdxBits-1:0]    cfg_index,
  input  logic [GainBits-1:0]      cfg_data
);

  // Sequencer codes
  localparam logic [4:0] StIdle  = 5'd0;
  localparam logic [4:0] StMeas  = 5'd1;
  localparam logic [4:0] StErr   = 5'd2;
  localparam logic [4:0] StPterm = 5'd3;
  localparam logic [4:0] StIterm = 5'd4;
  localparam logic [4:0] StDterm = 5'd5;
  localparam logic [4:0] StSum   = 5'd6;
  localparam logic [4:0] StAbs   = 5'd7;
  localparam logic [4:0] StDiv   = 5'd8;
  localparam logic [4:0] StDcor  = 5'd9;
  localparam logic [4:0] StClmp  = 5'd10;
  localparam logic [4:0] StScale = 5'd11;
  localparam logic [4:0] StRecip = 5'd12;
  localparam logic [4:0] StDq    = 5'd13;
  localparam logic [4:0] StDm    = 5'd14;
  localparam logic [4:0] StDfix  = 5'd15;
  localparam logic [4:0] StDone  = 5'd16;

  logic [4:0]              state;
  logic [GainBits-1:0]     gain_prop;
  logic [GainBits-1:0]     gain_integ;
  logic [GainBits-1:0]     gain_deriv;

  // Controller state
  logic signed [15:0]      integ_acc;
  logic [MvBits-1:0]       prev_meas_mv;
  logic [MvBits-1:0]       target_reg;
  logic                    paused_flag;
  logic [PwmBits-1:0]      duty_reg;
  logic [MvBits-1:0]       drive_reg;

  // Working registers
  logic [AdcBits-1:0]      sample;
  logic signed [MvBits:0]  err;
  logic signed [MvBits:0]  diff;
  logic signed [24:0]      acc;
  logic                    neg;
  logic [23:0]             mag;
  logic [20:0]             quo;
  logic [20:0]             pd;
  logic [PwmBits-1:0]      duty_q;
  mul_prod_t               prod;

  // Combinational helpers
  mul_op_t                 mul_a;
  mul_op_t                 mul_b;
  logic [MvBits-1:0]       meas;
  logic signed [MvBits:0]  err_c;
  logic signed [16:0]      integ_sum;
  logic signed [15:0]      integ_next;
  logic [20:0]             q0;
  logic [24:0]             tenq;
  logic [24:0]             rem10;
  logic [20:0]             rem_duty;
  logic                    out_free;
  logic [AdcBits-1:0]      in_sample;
  logic [MvBits-1:0]       in_target;

  assign in_sample = s_tdata[AdcBits-1:0];
  assign in_target = s_tdata[AdcBits+MvBits-1:AdcBits];
  assign s_tready  = (state == StIdle);
  assign out_free  = !m_tvalid || m_tready;

  // Measurement, error and integrator update
  assign meas      = prod[AdcBits+MvBits-1:AdcBits];
  assign err_c     = $signed({1'b0, target_reg}) - $signed({1'b0, meas});
  assign integ_sum = 17'(integ_acc) + 17'(err_c);
  always_comb begin
    if (integ_sum > 17'(Lim16)) begin
      integ_next = 16'(Lim16);
    end else if (integ_sum < -17'(Lim16)) begin
      integ_next = -16'(Lim16);
    end else begin
      integ_next = integ_sum[15:0];
    end
  end

  // Divide-by-ten correction and duty remainder
  assign q0       = prod[DivTenShift+20:DivTenShift];
  assign tenq     = {1'b0, q0, 3'b000} + {3'b000, q0, 1'b0};
  assign rem10    = {1'b0, mag} - tenq;
  assign rem_duty = pd - prod[20:0];

  // Select operands for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      StMeas: begin
        mul_a = MulBits'(sample);
        mul_b = MulBits'(RefMv);
      end
      StPterm: begin
        mul_a = MulBits'(gain_prop);
        mul_b = MulBits'(err);
      end
      StIterm: begin
        mul_a = MulBits'(gain_integ);
        mul_b = MulBits'(integ_acc);
      end
      StDterm: begin
        mul_a = MulBits'(gain_deriv);
        mul_b = MulBits'(diff);
      end
      StDiv: begin
        mul_a = MulBits'(mag);
        mul_b = MulBits'(DivTenRecip);
      end
      StScale: begin
        mul_a = MulBits'(drive_reg);
        mul_b = MulBits'(PwmMax);
      end
      StRecip: begin
        mul_a = MulBits'(prod[20:0]);
        mul_b = MulBits'(DutyRecip);
      end
      StDm: begin
        mul_a = MulBits'(duty_q);
        mul_b = MulBits'(RefMv);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Register the product every cycle
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop  <= GainPropRst;
      gain_integ <= GainIntegRst;
      gain_deriv <= GainDerivRst;
    end else if (cfg_we) begin
      case (cfg_index)
        RegGainProp:  gain_prop  <= cfg_data;
        RegGainInteg: gain_integ <= cfg_data;
        RegGainDeriv: gain_deriv <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath work registers
  always_ff @(posedge clk) begin
    case (state)
      StIdle: sample <= in_sample;
      StErr: begin
        err  <= err_c;
        diff <= $signed({1'b0, prev_meas_mv}) - $signed({1'b0, meas});
      end
      StIterm: acc <= prod[24:0];
      StDterm: acc <= acc + prod[24:0];
      StSum:   acc <= acc + prod[24:0];
      StAbs: begin
        neg <= acc[24];
        mag <= acc[24] ? 24'(-acc) : acc[23:0];
      end
      StDcor:  quo <= q0 + 21'(rem10 >= 25'd10);
      StRecip: pd <= prod[20:0];
      StDq:    duty_q <= prod[DutyShift+PwmBits-1:DutyShift];
      default: ;
    endcase
  end

  // Sequencer, controller state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= StIdle;
      m_tvalid     <= 1'b0;
      integ_acc    <= '0;
      prev_meas_mv <= '0;
      target_reg   <= '0;
      paused_flag  <= 1'b0;
      duty_reg     <= '0;
      drive_reg    <= '0;
    end else begin
      // Drop a taken word unless the next one loads in the same cycle
      if (m_tvalid && m_tready && state != StDone) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        StIdle: begin
          if (s_tvalid) begin
            state <= StDone;
            case (s_tuser)
              ActSample: begin
                if (!paused_flag) begin
                  state <= StMeas;
                end
              end
              ActTarget: begin
                target_reg <= in_target;
                integ_acc  <= '0;
              end
              ActPause: paused_flag <= !paused_flag;
              default: ;
            endcase
          end
        end
        StErr: begin
          integ_acc    <= integ_next;
          prev_meas_mv <= meas;
          state        <= StPterm;
        end
        StClmp: begin
          if (neg) begin
            drive_reg <= '0;
          end else if (quo > 21'(RefMv)) begin
            drive_reg <= MvBits'(RefMv);
          end else begin
            drive_reg <= quo[MvBits-1:0];
          end
          state <= StScale;
        end
        StDfix: begin
          duty_reg <= duty_q + PwmBits'(rem_duty >= 21'(RefMv));
          state    <= StDone;
        end
        StDone: begin
          // Hold until the result register is free
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= StIdle;
          end
        end
        default: state <= state + 5'd1;
      endcase
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (state == StDone && out_free) begin
      m_tdata <= OutDataBits'({drive_reg, duty_reg});
      m_tuser <= !paused_flag;
    end
  end

endmodule

[src/pvr_checker.sv]
module pvr_checker
  import pvr_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OutDataBits-1:0] m_tdata,
  input logic                   m_tuser
);

  // No result word right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  // A stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // Busy after taking a word
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after accepting a word");

  // Drive stays within the supply range
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[20:8] <= 13'd5000)
    else $error("drive above range");

  // Duty follows drive
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:0] == 8'((21'(m_tdata[20:8]) * 21'd255) / 21'd5000))
    else $error("duty does not match drive");

endmodule

bind pid_voltage_regulator_pwm pvr_checker u_pvr_checker (.*);
